// ===== rtl/core/emc_pkg.sv =====
// ----------------------------------------------------------------------------
// emc_pkg
// Shared types and fixed constants of the exhaustive maximum cut block.
// ----------------------------------------------------------------------------
package emc_pkg;

	// fixed field widths of the item and result ports
	localparam int IDX_W = 5;
	localparam int ROW_W = 20;
	localparam int OUT_W = 8;
	localparam int VCNT_W = 5;

	// vertex count after reset
	localparam logic [VCNT_W-1:0] VCNT_RESET = 5'd20;

	// control travelling with each row read of the search
	typedef struct packed {
		logic start;     // clear accumulator and best count
		logic valid;     // a row read lands this cycle
		logic row_end;   // last row of the current mask
		logic mask_end;  // last mask of the search
	} emc_ctl_t;

endpackage

// ===== rtl/core/exhaustive_max_cut.sv =====
// ----------------------------------------------------------------------------
// exhaustive_max_cut
// Loads adjacency rows, then searches every vertex subset for the largest cut.
// ----------------------------------------------------------------------------
// a row item with row_last low is taken and leaves the block ready.
// a row item with row_last high holds the block for the whole search,
// one row of one mask per cycle through the shared crossing-edge unit.
// the result sits in an output register; rows may load while it waits, and a
// later search holds the block until that register is free.
// reset: arst_n clears control and sets the vertex count to 20; rows are kept.
module exhaustive_max_cut #(
	parameter int MAX_VERTICES = 20
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [emc_pkg::IDX_W-1:0]    row_index,
	input  logic [emc_pkg::ROW_W-1:0]    row_bits,
	input  logic                         row_last,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [emc_pkg::OUT_W-1:0]    max_cut,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [emc_pkg::VCNT_W-1:0]   cfg_data
);

	localparam int VW = MAX_VERTICES;
	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int NW = $clog2(MAX_VERTICES + 1);
	localparam int CW = $clog2(MAX_VERTICES * MAX_VERTICES + 1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t                      state_q;
	logic [emc_pkg::VCNT_W-1:0]  vcount_q;
	logic [NW-1:0]               nsat;
	logic [VW-1:0]               used_d;
	logic [VW-1:0]               used_q;
	logic [AW-1:0]               last_row_q;
	logic [AW-1:0]               row_q;
	logic [VW-1:0]               mask_q;
	logic                        accept;
	logic                        start;
	logic                        issue;
	logic                        row_end;
	logic                        mask_end;
	emc_pkg::emc_ctl_t           ctl_s1;
	logic [AW-1:0]               row_s1;
	logic [VW-1:0]               mask_s1;
	logic                        mbit_s1;
	logic [emc_pkg::ROW_W-1:0]   rd_data;
	logic [CW-1:0]               best;
	logic                        done;
	logic                        out_load;
	logic                        out_valid_q;
	logic [emc_pkg::OUT_W-1:0]   max_cut_q;
	logic [CW-1:0]               half;

	assign cfg_ready = 1'b1;
	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && !in_stall;
	assign start = accept && row_last;

	// vertex count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= emc_pkg::VCNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			vcount_q <= cfg_data;
		end
	end

	// saturated vertex count and the mask of vertices in use
	always_comb begin
		if (32'(vcount_q) > MAX_VERTICES) begin
			nsat = NW'(MAX_VERTICES);
		end else begin
			nsat = NW'(vcount_q);
		end
		for (int k = 0; k < VW; k++) begin
			used_d[k] = (32'(k) < 32'(nsat));
		end
	end

	// row store
	emc_adj_mem #(
		.DEPTH (MAX_VERTICES),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (accept && (32'(row_index) < MAX_VERTICES)),
		.wr_addr (AW'(row_index)),
		.wr_data (row_bits),
		.rd_addr (row_q),
		.rd_data (rd_data)
	);

	assign issue = (state_q == ST_RUN);
	assign row_end = (row_q == last_row_q);
	assign mask_end = (mask_q == used_q);

	// search sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			used_q <= '0;
			last_row_q <= '0;
			row_q <= '0;
			mask_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						used_q <= used_d;
						last_row_q <= (nsat == '0) ? '0 : AW'(nsat - 1'b1);
						row_q <= '0;
						mask_q <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (row_end) begin
						row_q <= '0;
						if (mask_end) begin
							state_q <= ST_DRAIN;
						end else begin
							mask_q <= mask_q + 1'b1;
						end
					end else begin
						row_q <= row_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// control aligned with the registered row read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.start <= start;
			ctl_s1.valid <= issue;
			ctl_s1.row_end <= issue && row_end;
			ctl_s1.mask_end <= issue && mask_end;
		end
	end

	always_ff @(posedge clk) begin
		row_s1 <= row_q;
		mask_s1 <= mask_q;
		mbit_s1 <= mask_q[row_q];
	end

	emc_cut_unit #(
		.VW (VW),
		.AW (AW),
		.CW (CW)
	) u_cut (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl_s1),
		.rd_data (rd_data),
		.row_idx (row_s1),
		.mask    (mask_s1),
		.mbit    (mbit_s1),
		.used    (used_q),
		.best    (best),
		.done    (done)
	);

	// result register, loaded once the slot is free
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign half = best >> 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			max_cut_q <= emc_pkg::OUT_W'(half);
		end
	end

	assign out_valid = out_valid_q;
	assign max_cut = max_cut_q;

endmodule

// ===== rtl/core/emc_adj_mem.sv =====
// ----------------------------------------------------------------------------
// emc_adj_mem
// Adjacency row store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module emc_adj_mem #(
	parameter int DEPTH = 20,
	parameter int AW = 5
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic [emc_pkg::ROW_W-1:0]  wr_data,
	input  logic [AW-1:0]              rd_addr,
	output logic [emc_pkg::ROW_W-1:0]  rd_data
);

	logic [emc_pkg::ROW_W-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== rtl/core/emc_cut_unit.sv =====
// ----------------------------------------------------------------------------
// emc_cut_unit
// Shared crossing-edge unit: counts one row's crossing edges per cycle,
// accumulates them over a mask and keeps the best mask total.
// ----------------------------------------------------------------------------
module emc_cut_unit #(
	parameter int VW = 20,
	parameter int AW = 5,
	parameter int CW = 9
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  emc_pkg::emc_ctl_t          ctl,
	input  logic [emc_pkg::ROW_W-1:0]  rd_data,
	input  logic [AW-1:0]              row_idx,
	input  logic [VW-1:0]              mask,
	input  logic                       mbit,
	input  logic [VW-1:0]              used,
	output logic [CW-1:0]              best,
	output logic                       done
);

	localparam int PW = $clog2(VW + 1);

	logic [VW-1:0] row_v;
	logic [VW-1:0] eff;
	logic [PW-1:0] pop;
	logic [CW-1:0] sum;
	logic [CW-1:0] acc_q;
	logic [CW-1:0] best_q;
	logic          done_q;

	// edges of this row whose far end lies on the other side
	always_comb begin
		row_v = VW'(rd_data);
		eff = row_v & used & ~(VW'(1) << row_idx) & (mbit ? ~mask : mask);
		pop = '0;
		for (int k = 0; k < VW; k++) begin
			pop = pop + PW'(eff[k]);
		end
		sum = acc_q + CW'(pop);
	end

	// accumulate over the mask, keep the largest total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			best_q <= '0;
			done_q <= 1'b0;
		end else if (ctl.start) begin
			acc_q <= '0;
			best_q <= '0;
			done_q <= 1'b0;
		end else if (ctl.valid) begin
			if (ctl.row_end) begin
				acc_q <= '0;
				if (sum > best_q) begin
					best_q <= sum;
				end
				done_q <= ctl.mask_end;
			end else begin
				acc_q <= sum;
				done_q <= 1'b0;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign best = best_q;
	assign done = done_q;

endmodule

// ===== rtl/core/emc_checker.sv =====
// ----------------------------------------------------------------------------
// emc_checker
// Port-level checks of the exhaustive maximum cut block, bound to the top.
// ----------------------------------------------------------------------------
module emc_checker #(
	parameter int MAX_VERTICES = 20
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        row_last,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [emc_pkg::OUT_W-1:0]   max_cut
);

	localparam int CUT_LIMIT = MAX_VERTICES * (MAX_VERTICES - 1) / 2;

	// a waiting result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(max_cut))
		else $error("result changed while stalled");

	// a cut never exceeds half the directed edge count
	a_cut_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(max_cut) <= CUT_LIMIT))
		else $error("cut above edge bound");

	// the last row starts a search that holds off further rows
	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && row_last |=> in_stall)
		else $error("no search after last row");

	// an ordinary row leaves the block ready
	a_row_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !row_last |=> !in_stall)
		else $error("busy after ordinary row");

	// a new result only comes out of a search
	a_out_after_search: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without search");

endmodule

bind exhaustive_max_cut emc_checker #(
	.MAX_VERTICES (MAX_VERTICES)
) u_emc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.row_last  (row_last),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.max_cut   (max_cut)
);

// ===== tb/exhaustive_max_cut_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exhaustive_max_cut_test
// Self-checking bench for the brute-force maximum cut block. Adjacency rows
// are streamed in under random idling on both sides. Each row marked last is
// scored by a local exhaustive search over every vertex subset, or taken from
// the directed table's known cut; the result is queued and matched against the
// block's output. A short directed table runs first. Random load and search
// sequences follow, mostly on small graphs so that run time stays bounded.
// ----------------------------------------------------------------------------
module exhaustive_max_cut_test;

	localparam int MAX_V = 20;
	localparam int PERIOD = 10;
	localparam int RESET_CYCLES = 12;
	localparam int SETTLE = 8;
	localparam int LONG_HOLD = 2000;
	localparam int HEAVY_N = 12;
	localparam int ITEMS_GOAL = 400;
	localparam int CUTS_GOAL = 48;
	localparam int LIMIT = 4000000;
	localparam int N_DIRECTED = 27;

	typedef logic [emc_pkg::ROW_W-1:0] row_t;
	typedef logic [emc_pkg::IDX_W-1:0] idx_t;
	typedef logic [emc_pkg::OUT_W-1:0] cut_t;
	typedef logic [emc_pkg::VCNT_W-1:0] vcnt_t;

	typedef enum logic {STEP_ROW, STEP_VCNT} step_kind_t;

	// one directed step; a vertex count step carries the count in idx
	typedef struct packed {
		step_kind_t kind;
		idx_t       idx;
		row_t       bits;
		logic       last;
		logic       known_ok;
		cut_t       known;
	} dir_step_t;

	logic  clk = 1'b0;
	logic  arst_n;
	logic  in_valid;
	logic  in_stall;
	idx_t  row_index;
	row_t  row_bits;
	logic  row_last;
	logic  out_valid;
	logic  out_stall;
	cut_t  max_cut;
	logic  cfg_valid;
	logic  cfg_ready;
	vcnt_t cfg_data;

	// local copy of the block's state
	row_t  adj_rows [MAX_V];
	bit    rows_written [MAX_V];
	vcnt_t vertex_cnt = emc_pkg::VCNT_RESET;

	cut_t  pending_cuts [$];
	int    errors = 0;
	int    items_sent = 0;
	int    cycle_count = 0;
	bit    tx_gaps = 1'b1;
	bit    rx_gaps = 1'b1;
	bit    hold_req = 1'b0;

	dir_step_t directed_steps [N_DIRECTED] = '{
		// empty graph setting: only the empty subset is tried
		'{STEP_VCNT, 5'd0,  20'h00000, 1'b0, 1'b0, 8'd0},
		'{STEP_ROW,  5'd0,  20'h00000, 1'b1, 1'b1, 8'd0},
		// single vertex: diagonal and high bits ignored
		'{STEP_VCNT, 5'd1,  20'h00000, 1'b0, 1'b0, 8'd0},
		'{STEP_ROW,  5'd0,  20'hFFFFF, 1'b1, 1'b1, 8'd0},
		// one directed edge halves to zero, both directions to one
		'{STEP_VCNT, 5'd2,  20'h00000, 1'b0, 1'b0, 8'd0},
		'{STEP_ROW,  5'd0,  20'hFFFFE, 1'b0, 1'b0, 8'd0},
		'{STEP_ROW,  5'd1,  20'h00000, 1'b1, 1'b1, 8'd0},
		'{STEP_ROW,  5'd1,  20'hFFFFF, 1'b1, 1'b1, 8'd1},
		// complete graph on four vertices
		'{STEP_VCNT, 5'd4,  20'h00000, 1'b0, 1'b0, 8'd0},
		'{STEP_ROW,  5'd0,  20'hFFFFF, 1'b0, 1'b0, 8'd0},
		'{STEP_ROW,  5'd1,  20'hFFFFF, 1'b0, 1'b0, 8'd0},
		'{STEP_ROW,  5'd2,  20'hFFFFF, 1'b0, 1'b0, 8'd0},
		'{STEP_ROW,  5'd3,  20'hFFFFF, 1'b1, 1'b1, 8'd4},
		// out of range row stores nothing but still searches
		'{STEP_ROW,  5'd31, 20'h00000, 1'b1, 1'b1, 8'd4},
		'{STEP_ROW,  5'd20, 20'h00000, 1'b0, 1'b0, 8'd0},
		'{STEP_ROW,  5'd3,  20'h00001, 1'b1, 1'b0, 8'd0},
		'{STEP_ROW,  5'd19, 20'hAAAAA, 1'b0, 1'b0, 8'd0},
		'{STEP_ROW,  5'd2,  20'h00000, 1'b1, 1'b0, 8'd0},
		// oversized count saturates; loads only, no search
		'{STEP_VCNT, 5'd31, 20'h00000, 1'b0, 1'b0, 8'd0},
		'{STEP_ROW,  5'd7,  20'h55555, 1'b0, 1'b0, 8'd0},
		'{STEP_VCNT, 5'd20, 20'h00000, 1'b0, 1'b0, 8'd0},
		'{STEP_ROW,  5'd19, 20'hFFFFF, 1'b0, 1'b0, 8'd0},
		// complete graph on three vertices, then a row above the count
		'{STEP_VCNT, 5'd3,  20'h00000, 1'b0, 1'b0, 8'd0},
		'{STEP_ROW,  5'd0,  20'h00006, 1'b0, 1'b0, 8'd0},
		'{STEP_ROW,  5'd1,  20'h00005, 1'b0, 1'b0, 8'd0},
		'{STEP_ROW,  5'd2,  20'h00003, 1'b1, 1'b1, 8'd2},
		'{STEP_ROW,  5'd12, 20'h00000, 1'b1, 1'b1, 8'd2}
	};

	exhaustive_max_cut #(
		.MAX_VERTICES(MAX_V)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.row_index (row_index),
		.row_bits  (row_bits),
		.row_last  (row_last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.max_cut   (max_cut),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #(PERIOD / 2) clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("FAIL exhaustive_max_cut");
			$finish;
		end
	end

	// best crossing count over every subset of the vertices in use, halved
	function automatic cut_t search_max_cut();
		int   n;
		int   m;
		int   i;
		int   cnt;
		int   best;
		row_t used;
		row_t mk;
		row_t row;
		n = (vertex_cnt > MAX_V) ? MAX_V : int'(vertex_cnt);
		used = row_t'((1 << n) - 1);
		best = 0;
		for (m = 0; m < (1 << n); m++) begin
			mk = m[emc_pkg::ROW_W-1:0];
			cnt = 0;
			for (i = 0; i < n; i++) begin
				row = adj_rows[i] & used & ~(row_t'(1) << i);
				if (mk[i])
					cnt += $countones(row & ~mk);
				else
					cnt += $countones(row & mk);
			end
			if (cnt > best)
				best = cnt;
		end
		return cut_t'(best / 2);
	endfunction

	// random row with varying density
	function automatic row_t draw_row();
		row_t v;
		v = row_t'($urandom);
		case ($urandom_range(0, 3))
			0: v = v & row_t'($urandom);
			1: v = v | row_t'($urandom);
			default: ;
		endcase
		return v;
	endfunction

	// offer one row item, then mirror it into the local store once taken
	task automatic put_row(input idx_t idx, input row_t bits, input logic last,
	                       input logic known_ok, input cut_t known);
		int gap;
		gap = tx_gaps ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		row_index <= idx;
		row_bits <= bits;
		row_last <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (idx < MAX_V) begin
			adj_rows[idx] = bits;
			rows_written[idx] = 1'b1;
		end
		if (last)
			pending_cuts = {pending_cuts, (known_ok ? known : search_max_cut())};
		items_sent++;
	endtask

	// hold the sender until every result is back and the block has settled
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_cuts.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_vcnt(input vcnt_t v);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		vertex_cnt = v;
	endtask

	// result side: random stall per item, one long hold-off on request
	initial begin : receiver
		int   wait_n;
		cut_t want;
		out_stall = 1'b1;
		wait (arst_n === 1'b1);
		forever begin
			wait_n = rx_gaps ? $urandom_range(0, 9) : 0;
			if (hold_req) begin
				wait_n = LONG_HOLD;
				hold_req = 1'b0;
			end
			if (wait_n > 0) begin
				out_stall <= 1'b1;
				repeat (wait_n) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			if (pending_cuts.size() == 0) begin
				$display("%0t: max_cut with nothing pending, expected none actual %0d",
				         $time, max_cut);
				errors++;
			end else begin
				want = pending_cuts.pop_front();
				if (max_cut !== want) begin
					$display("%0t: max_cut mismatch, expected %0d actual %0d",
					         $time, want, max_cut);
					errors++;
				end
			end
		end
	end

	// item side: reset, directed table, then random load and search phases
	initial begin : sender
		int   s;
		int   phase;
		int   n;
		int   searches;
		int   k;
		int   j;
		int   r;
		int   base;
		int   idx_last;
		int   cuts_due;
		int   items_goal;
		arst_n = 1'b0;
		in_valid = 1'b0;
		row_index = '0;
		row_bits = '0;
		row_last = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (s = 0; s < N_DIRECTED; s++) begin
			if (directed_steps[s].kind == STEP_VCNT)
				write_vcnt(vcnt_t'(directed_steps[s].idx));
			else
				put_row(directed_steps[s].idx, directed_steps[s].bits,
				        directed_steps[s].last, directed_steps[s].known_ok,
				        directed_steps[s].known);
		end

		// random phases, each under one vertex count
		phase = 0;
		cuts_due = 0;
		items_goal = items_sent + ITEMS_GOAL;
		while (items_sent < items_goal || cuts_due < CUTS_GOAL) begin
			tx_gaps = ($urandom_range(0, 3) != 0);
			rx_gaps = ($urandom_range(0, 3) != 0);
			if (phase == 1 || phase == 7) begin
				n = HEAVY_N;
				searches = 1;
			end else if (phase == 3) begin
				n = 3;
				searches = 4;
			end else begin
				case ($urandom_range(0, 15))
					0:       n = 0;
					1, 2, 3: n = $urandom_range(7, 10);
					default: n = $urandom_range(1, 6);
				endcase
				searches = $urandom_range(1, 3);
			end
			write_vcnt(vcnt_t'(n));
			// long receiver hold-off while the sender keeps offering items
			if (phase == 3) begin
				tx_gaps = 1'b0;
				hold_req = 1'b1;
			end
			for (k = 0; k < searches; k++) begin
				base = $urandom_range(0, MAX_V - 1);
				for (j = 0; j < n; j++) begin
					r = (base + j) % n;
					if (!rows_written[r] || $urandom_range(0, 3) != 0)
						put_row(idx_t'(r), draw_row(), 1'b0, 1'b0, '0);
					// stray row, any index
					if ($urandom_range(0, 9) == 0)
						put_row(idx_t'($urandom_range(0, 31)), draw_row(), 1'b0, 1'b0, '0);
				end
				// abandoned load, no search; never in the hold-off phase
				if (phase != 3 && $urandom_range(0, 11) == 0)
					continue;
				if ($urandom_range(0, 3) == 0)
					idx_last = $urandom_range(MAX_V, 31);
				else
					idx_last = $urandom_range(0, MAX_V - 1);
				put_row(idx_t'(idx_last), draw_row(), 1'b1, 1'b0, '0);
				cuts_due++;
			end
			phase++;
		end

		wait_idle();
		if (errors == 0)
			$display("PASS exhaustive_max_cut");
		else
			$display("FAIL exhaustive_max_cut");
		$finish;
	end

endmodule
